FILE: rtl/local_maximum_3x3_detector_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 3x3 local maximum detector
// Concurrent assertion shorthands used by the checker.
// ----------------------------------------------------------------------------
`ifndef LOCAL_MAXIMUM_3X3_DETECTOR_CORE_MACROS_SVH
`define LOCAL_MAXIMUM_3X3_DETECTOR_CORE_MACROS_SVH

// check on every edge, reset included
`define LM3_ASSERT(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// check only while out of reset
`define LM3_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

FILE: rtl/lm3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lm3_pkg
// Types, constants and helpers shared by the 3x3 local maximum detector.
// ----------------------------------------------------------------------------
package lm3_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int PEAK_W       = 7;
  localparam int DIM_W        = 8;
  localparam int CFG_IDX_W    = 2;
  localparam int MAX_ROWS_DEF = 128;
  localparam int MAX_COLS_DEF = 128;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(128);

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = CFG_IDX_W'(1);

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_DRAIN  = 1'b1;

  localparam int ROW_OFFSET [9] = '{-1, -1, -1, 0, 0, 0, 1, 1, 1};
  localparam int COL_OFFSET [9] = '{-1, 0, 1, -1, 0, 1, -1, 0, 1};

  typedef struct packed {
    logic                       cmd;
    logic signed [SAMPLE_W-1:0] sample;
  } lm3_in_t;

  typedef struct packed {
    logic [PEAK_W-1:0] peak_row;
    logic [PEAK_W-1:0] peak_col;
  } lm3_out_t;

  function automatic int clamp_dim(input logic [DIM_W-1:0] v, input int hi);
    int r;
    r = int'(v);
    if (r == 0) begin
      r = 1;
    end else if (r > hi) begin
      r = hi;
    end
    return r;
  endfunction

endpackage

FILE: rtl/local_maximum_3x3_detector_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// local_maximum_3x3_detector_core
// Streaming 3x3 local maximum detector over a row-major grid.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one sample (cmd = 0) or drain tick (cmd = 1) per transaction,
//            row-major; send grid_cols + 1 drain ticks after the last sample.
//   out_*  : one transaction per sample that no in-grid neighbor exceeds,
//            carrying its row and column.
//   cfg_*  : register 0 = grid_rows, register 1 = grid_cols; a write to either
//            restarts the frame. cfg_ready is always high. Write only while idle.
// Throughput: one item per clock unless stalled. The two line buffers share one
//   RAM entry per column; the read of the next column is issued on the same edge
//   that accepts the current item, so the RAM port never limits the rate.
// Latency: the decision for the sample at stream position q is loaded into
//   the output register on the edge that accepts position q + grid_cols + 1
//   and is driven on out_* directly after that edge.
// Reset: positions and window clear, grid size returns to 128 x 128; the
//   line RAM needs no clearing since border masking hides stale entries.
// Stall: while a result waits under out_stall, in_stall is raised and
//   all state holds.
// ----------------------------------------------------------------------------
module local_maximum_3x3_detector_core #(
  parameter int MAX_ROWS = lm3_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = lm3_pkg::MAX_COLS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  lm3_pkg::lm3_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output lm3_pkg::lm3_out_t               out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lm3_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lm3_pkg::DIM_W-1:0]       cfg_data
);

  localparam int SW  = lm3_pkg::SAMPLE_W;
  localparam int CW  = $clog2(MAX_COLS);
  localparam int CLW = $clog2(MAX_COLS + 1);
  localparam int RW  = $clog2(MAX_ROWS + 2);
  localparam int PW  = lm3_pkg::PEAK_W;

  logic [RW-1:0]          rows_r, rows_nxt;
  logic [CLW-1:0]         cols_r, cols_nxt;
  logic [RW-1:0]          ar_r, ar_nxt, ar_adv;
  logic [CW-1:0]          ac_r, ac_nxt, ac_adv;
  logic [CW:0]            col_inc;
  logic                   out_valid_r, out_valid_nxt;
  lm3_pkg::lm3_out_t      out_data_r, out_data_nxt;
  logic                   byp_r, byp_nxt;
  logic [2*SW-1:0]        byp_data_r;
  logic signed [SW-1:0]   win_r [9];
  logic signed [SW-1:0]   win_nxt [9];

  logic                   in_acc, cfg_we, restart, wrap;
  logic [CW-1:0]          rd_addr;
  logic [2*SW-1:0]        ram_rdata, line_rd, line_wr;
  logic signed [SW-1:0]   top, mid, v;
  logic                   mid_col, dec_ok, up_ok, down_ok, left_ok, right_ok;
  logic                   peak, row_ok, col_ok;
  logic [RW-1:0]          cr;
  logic [PW-1:0]          cc;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign restart   = cfg_we && ((cfg_index == lm3_pkg::CFG_GRID_ROWS) ||
                                (cfg_index == lm3_pkg::CFG_GRID_COLS));
  assign in_stall  = out_valid_r && out_stall;
  assign in_acc    = in_valid && !in_stall;

  assign line_rd = byp_r ? byp_data_r : ram_rdata;
  assign top     = line_rd[2*SW-1:SW];
  assign mid     = line_rd[SW-1:0];
  assign v       = (in_data.cmd == lm3_pkg::CMD_DRAIN) ? '0 : in_data.sample;
  assign line_wr = {mid, v};

  always_comb begin
    rows_nxt = rows_r;
    cols_nxt = cols_r;
    if (cfg_we && (cfg_index == lm3_pkg::CFG_GRID_ROWS)) begin
      rows_nxt = RW'(lm3_pkg::clamp_dim(cfg_data, MAX_ROWS));
    end
    if (cfg_we && (cfg_index == lm3_pkg::CFG_GRID_COLS)) begin
      cols_nxt = CLW'(lm3_pkg::clamp_dim(cfg_data, MAX_COLS));
    end
  end

  always_comb begin
    col_inc = {1'b0, ac_r} + (CW + 1)'(1);
    wrap    = (ac_r == '0) && (ar_r > rows_r);
    ac_adv  = CW'(col_inc);
    ar_adv  = ar_r;
    if (wrap) begin
      ac_adv = '0;
      ar_adv = '0;
    end else if (col_inc >= (CW + 1)'(cols_r)) begin
      ac_adv = '0;
      ar_adv = ar_r + RW'(1);
    end
    if (restart) begin
      ac_nxt = '0;
      ar_nxt = '0;
    end else if (in_acc) begin
      ac_nxt = ac_adv;
      ar_nxt = ar_adv;
    end else begin
      ac_nxt = ac_r;
      ar_nxt = ar_r;
    end
  end

  assign rd_addr = rst_n ? ac_nxt : '0;
  assign byp_nxt = in_acc && (rd_addr == ac_r);

  lm3_ram #(
    .WIDTH (2 * SW),
    .DEPTH (MAX_COLS)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (in_acc),
    .wr_addr (ac_r),
    .wr_data (line_wr),
    .rd_addr (rd_addr),
    .rd_data (ram_rdata)
  );

  always_comb begin
    mid_col  = (ac_r != '0);
    dec_ok   = mid_col ? ((ar_r >= RW'(1)) && (ar_r <= rows_r)) : (ar_r >= RW'(2));
    up_ok    = mid_col ? (ar_r >= RW'(2)) : (ar_r >= RW'(3));
    down_ok  = mid_col ? (ar_r < rows_r) : (ar_r <= rows_r);
    left_ok  = mid_col ? (ac_r >= CW'(2)) : (cols_r >= CLW'(2));
    right_ok = mid_col;
    cr       = mid_col ? (ar_r - RW'(1)) : (ar_r - RW'(2));
    cc       = mid_col ? PW'(ac_r - CW'(1)) : PW'(cols_r - CLW'(1));
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r*3]     = win_r[r*3+1];
      win_nxt[r*3 + 1] = win_r[r*3+2];
    end
    win_nxt[2] = top;
    win_nxt[5] = mid;
    win_nxt[8] = v;
  end

  always_comb begin
    peak = 1'b1;
    for (int d = 0; d < 9; d++) begin
      row_ok = (lm3_pkg::ROW_OFFSET[d] < 0) ? up_ok :
               (lm3_pkg::ROW_OFFSET[d] > 0) ? down_ok : 1'b1;
      col_ok = (lm3_pkg::COL_OFFSET[d] < 0) ? left_ok :
               (lm3_pkg::COL_OFFSET[d] > 0) ? right_ok : 1'b1;
      if (row_ok && col_ok && (win_nxt[d] > win_nxt[4])) begin
        peak = 1'b0;
      end
    end
  end

  always_comb begin
    out_data_nxt = out_data_r;
    if (in_acc) begin
      out_valid_nxt         = dec_ok && peak;
      out_data_nxt.peak_row = PW'(cr);
      out_data_nxt.peak_col = cc;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r      <= RW'(lm3_pkg::clamp_dim(lm3_pkg::DIM_RESET, MAX_ROWS));
      cols_r      <= CLW'(lm3_pkg::clamp_dim(lm3_pkg::DIM_RESET, MAX_COLS));
      ar_r        <= '0;
      ac_r        <= '0;
      out_valid_r <= 1'b0;
      byp_r       <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      rows_r      <= rows_nxt;
      cols_r      <= cols_nxt;
      ar_r        <= ar_nxt;
      ac_r        <= ac_nxt;
      out_valid_r <= out_valid_nxt;
      byp_r       <= byp_nxt;
      for (int i = 0; i < 9; i++) begin
        if (restart) begin
          win_r[i] <= '0;
        end else if (in_acc) begin
          win_r[i] <= win_nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    byp_data_r <= line_wr;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/lm3_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lm3_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lm3_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/lm3_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lm3_checker
// Port-level assertions for the 3x3 local maximum detector, bound to the top.
// ----------------------------------------------------------------------------
`include "local_maximum_3x3_detector_core_macros.svh"

module lm3_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input lm3_pkg::lm3_out_t out_data
);

  `LM3_ASSERT(a_reset_clears_out, clk, !rst_n |=> !out_valid, "output valid after reset")
  `LM3_ASSERT_RST(a_out_holds, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled result changed")
  `LM3_ASSERT_RST(a_stall_cause, clk, rst_n, in_stall |-> out_valid && out_stall, "input stalled without blocked output")
  `LM3_ASSERT_RST(a_result_source, clk, rst_n, out_valid && !$past(out_valid && out_stall) |-> $past(in_valid && !in_stall), "result without accepted item")

endmodule

bind local_maximum_3x3_detector_core lm3_checker u_lm3_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

FILE: tb/sv/local_maximum_3x3_detector_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// local_maximum_3x3_detector_core_test
// Self-checking bench for the streaming 3x3 peak detector. A short table of
// directed transactions covers register extremes, 1x1 grids and misplaced
// samples and drain ticks; random frames of many sizes and value styles
// follow. Every accepted input runs through a cycle-free grid predictor, and
// each accepted peak is compared with the oldest predicted one. Sender bursts
// and receiver stall patterns vary throughout.
// ----------------------------------------------------------------------------
module local_maximum_3x3_detector_core_test;

  localparam int  RANDOM_ITEMS = 1250;
  localparam int  HOLD_OFF     = 4;
  localparam int  SETTLE       = 16;
  localparam int  WATCHDOG     = 2000;
  localparam int  LINE_DEPTH   = 128;
  localparam logic [lm3_pkg::CFG_IDX_W-1:0] CFG_UNUSED = lm3_pkg::CFG_IDX_W'(3);

  typedef enum logic [1:0] {CHK_PREDICT, CHK_SILENT, CHK_ORIGIN} check_t;

  typedef struct {
    bit                            is_cfg;
    logic [lm3_pkg::CFG_IDX_W-1:0] idx;
    logic [lm3_pkg::DIM_W-1:0]     val;
    lm3_pkg::lm3_in_t              item;
    check_t                        check;
  } stim_row_t;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  lm3_pkg::lm3_in_t              in_data;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  lm3_pkg::lm3_out_t             out_data;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [lm3_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [lm3_pkg::DIM_W-1:0]     cfg_data;

  // grid predictor state
  logic signed [lm3_pkg::SAMPLE_W-1:0] line_two_back [LINE_DEPTH];
  logic signed [lm3_pkg::SAMPLE_W-1:0] line_one_back [LINE_DEPTH];
  logic signed [lm3_pkg::SAMPLE_W-1:0] nbhd [9];
  int                                  scan_row;
  int                                  scan_col;
  logic [lm3_pkg::DIM_W-1:0]           grid_rows_q;
  logic [lm3_pkg::DIM_W-1:0]           grid_cols_q;

  lm3_pkg::lm3_out_t peaks_due [$];
  check_t            row_check;
  int                bad_count;
  int                random_items;
  int                burst_left;
  bit                tx_quiet;
  int                idle_cycles;
  int                stall_left;
  int                stall_mode;
  int                stall_period;
  int                stall_duty;
  int                stall_tick;
  stim_row_t         directed [$];

  local_maximum_3x3_detector_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int grid_extent(input logic [lm3_pkg::DIM_W-1:0] raw);
    int v;
    v = int'(raw);
    if (v == 0) begin
      v = 1;
    end else if (v > LINE_DEPTH) begin
      v = LINE_DEPTH;
    end
    return v;
  endfunction

  function automatic void restart_scan();
    for (int i = 0; i < 9; i++) begin
      nbhd[i] = '0;
    end
    scan_row = 0;
    scan_col = 0;
  endfunction

  // Shift one transaction into the window and decide the centre it completes.
  function automatic bit advance_grid(input lm3_pkg::lm3_in_t item,
                                      output lm3_pkg::lm3_out_t peak);
    int rows, cols, ar, ac, cr, cc, nr, nc;
    logic signed [lm3_pkg::SAMPLE_W-1:0] v, top, mid;
    bit hit, found;
    rows = grid_extent(grid_rows_q);
    cols = grid_extent(grid_cols_q);
    ar = scan_row;
    ac = scan_col;
    v = (item.cmd == lm3_pkg::CMD_DRAIN) ? '0 : item.sample;
    top = line_two_back[ac];
    mid = line_one_back[ac];
    line_two_back[ac] = mid;
    line_one_back[ac] = v;
    for (int r = 0; r < 3; r++) begin
      nbhd[r * 3] = nbhd[r * 3 + 1];
      nbhd[r * 3 + 1] = nbhd[r * 3 + 2];
    end
    nbhd[2] = top;
    nbhd[5] = mid;
    nbhd[8] = v;
    if (ac >= 1) begin
      hit = ar >= 1;
      cr = ar - 1;
      cc = ac - 1;
    end else begin
      hit = ar >= 2;
      cr = ar - 2;
      cc = cols - 1;
    end
    found = 1'b0;
    peak = '0;
    if (hit && cr < rows) begin
      found = 1'b1;
      for (int d = 0; d < 9; d++) begin
        nr = cr + d / 3 - 1;
        nc = cc + d % 3 - 1;
        if (nr >= 0 && nr < rows && nc >= 0 && nc < cols && nbhd[d] > nbhd[4]) begin
          found = 1'b0;
        end
      end
      peak.peak_row = lm3_pkg::PEAK_W'(cr);
      peak.peak_col = lm3_pkg::PEAK_W'(cc);
    end
    if (ac == 0 && ar >= rows + 1) begin
      scan_row = 0;
      scan_col = 0;
    end else begin
      ac++;
      if (ac >= cols) begin
        ac = 0;
        ar++;
      end
      scan_row = ar;
      scan_col = ac;
    end
    return found;
  endfunction

  always @(posedge clk) begin : scoreboard
    lm3_pkg::lm3_out_t predicted;
    lm3_pkg::lm3_out_t wanted;
    bit found;
    if (!rst_n) begin
      grid_rows_q = lm3_pkg::DIM_RESET;
      grid_cols_q = lm3_pkg::DIM_RESET;
      for (int i = 0; i < LINE_DEPTH; i++) begin
        line_two_back[i] = '0;
        line_one_back[i] = '0;
      end
      restart_scan();
    end else begin
      if (in_valid && !in_stall) begin
        found = advance_grid(in_data, predicted);
        if (row_check == CHK_ORIGIN) begin
          peaks_due.push_back('0);
        end else if (row_check == CHK_PREDICT && found) begin
          peaks_due.push_back(predicted);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lm3_pkg::CFG_GRID_ROWS: begin
            grid_rows_q = cfg_data;
            restart_scan();
          end
          lm3_pkg::CFG_GRID_COLS: begin
            grid_cols_q = cfg_data;
            restart_scan();
          end
          default: begin
          end
        endcase
      end
      if (out_valid && !out_stall) begin
        if (peaks_due.size() == 0) begin
          bad_count++;
          if (bad_count <= 10) begin
            $display("unexpected peak: row %0d col %0d", out_data.peak_row,
                     out_data.peak_col);
          end
        end else begin
          wanted = peaks_due.pop_front();
          if (wanted.peak_row !== out_data.peak_row ||
              wanted.peak_col !== out_data.peak_col) begin
            bad_count++;
            if (bad_count <= 10) begin
              $display("peak mismatch: expected row %0d col %0d, got row %0d col %0d",
                       wanted.peak_row, wanted.peak_col, out_data.peak_row,
                       out_data.peak_col);
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver backpressure: duty-cycle pattern, re-picked every stretch
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_left = $urandom_range(16, 160);
      stall_mode = $urandom_range(0, 3);
      stall_period = $urandom_range(2, 12);
      stall_duty = $urandom_range(1, stall_period - 1);
    end
    stall_left--;
    stall_tick++;
    out_stall = rst_n && stall_mode != 0 && (stall_tick % stall_period) < stall_duty;
  end

  task automatic drive_item(input lm3_pkg::lm3_in_t item, input check_t check);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (tx_quiet) begin
        gap = 0;
      end else if ($urandom_range(0, 7) == 0) begin
        gap = $urandom_range(8, 15);
      end else begin
        gap = $urandom_range(0, 3);
      end
      if (gap != 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid = 1'b1;
    in_data = item;
    row_check = check;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [lm3_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lm3_pkg::DIM_W-1:0] val);
    in_valid = 1'b0;
    while (peaks_due.size() != 0) @(negedge clk);
    repeat (HOLD_OFF) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [lm3_pkg::SAMPLE_W-1:0] pick_value(
      input int style, input logic [lm3_pkg::SAMPLE_W-1:0] flat);
    logic [lm3_pkg::SAMPLE_W-1:0] v;
    case (style)
      0: v = lm3_pkg::SAMPLE_W'($urandom);
      1: v = lm3_pkg::SAMPLE_W'($urandom_range(0, 3)) - lm3_pkg::SAMPLE_W'(1);
      2: begin
        case ($urandom_range(0, 3))
          0: v = {1'b1, {(lm3_pkg::SAMPLE_W - 1){1'b0}}};
          1: v = {1'b0, {(lm3_pkg::SAMPLE_W - 1){1'b1}}};
          2: v = '0;
          default: v = '1;
        endcase
      end
      default: v = flat;
    endcase
    return v;
  endfunction

  task automatic send_frame(input int rows, input int cols, input bit cut);
    int body, total, last, style;
    logic [lm3_pkg::SAMPLE_W-1:0] flat;
    lm3_pkg::lm3_in_t item;
    body = rows * cols;
    total = body + cols + 1;
    last = cut ? $urandom_range(0, total - 1) : total;
    style = $urandom_range(0, 3);
    flat = lm3_pkg::SAMPLE_W'($urandom);
    for (int k = 0; k < last; k++) begin
      if (k < body) begin
        item.cmd = ($urandom_range(0, 29) == 0) ? lm3_pkg::CMD_DRAIN : lm3_pkg::CMD_SAMPLE;
      end else begin
        item.cmd = ($urandom_range(0, 7) == 0) ? lm3_pkg::CMD_SAMPLE : lm3_pkg::CMD_DRAIN;
      end
      item.sample = (item.cmd == lm3_pkg::CMD_SAMPLE) ? pick_value(style, flat) :
                    lm3_pkg::SAMPLE_W'($urandom);
      drive_item(item, CHK_PREDICT);
      random_items++;
    end
  endtask

  task automatic run_phase();
    int pick, frames;
    logic [lm3_pkg::DIM_W-1:0] rows_raw, cols_raw;
    pick = $urandom_range(0, 19);
    frames = $urandom_range(1, 3);
    case (pick)
      0: begin
        rows_raw = lm3_pkg::DIM_W'($urandom_range(128, 255));
        cols_raw = lm3_pkg::DIM_W'($urandom_range(0, 1));
        frames = 1;
      end
      1: begin
        rows_raw = lm3_pkg::DIM_W'($urandom_range(1, 2));
        cols_raw = lm3_pkg::DIM_W'($urandom_range(128, 255));
        frames = 1;
      end
      2: begin
        rows_raw = '0;
        cols_raw = lm3_pkg::DIM_W'($urandom_range(1, 10));
      end
      3: begin
        rows_raw = lm3_pkg::DIM_W'($urandom_range(1, 10));
        cols_raw = '0;
      end
      default: begin
        rows_raw = lm3_pkg::DIM_W'($urandom_range(1, 8));
        cols_raw = lm3_pkg::DIM_W'($urandom_range(1, 10));
      end
    endcase
    tx_quiet = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 1) == 0) begin
      write_reg(lm3_pkg::CFG_GRID_ROWS, rows_raw);
      write_reg(lm3_pkg::CFG_GRID_COLS, cols_raw);
    end else begin
      write_reg(lm3_pkg::CFG_GRID_COLS, cols_raw);
      write_reg(lm3_pkg::CFG_GRID_ROWS, rows_raw);
    end
    if ($urandom_range(0, 9) == 0) begin
      write_reg(CFG_UNUSED, lm3_pkg::DIM_W'($urandom));
    end
    for (int f = 0; f < frames; f++) begin
      send_frame(grid_extent(rows_raw), grid_extent(cols_raw),
                 f == frames - 1 && $urandom_range(0, 9) == 0);
    end
  endtask

  function automatic stim_row_t cfg_row(input logic [lm3_pkg::CFG_IDX_W-1:0] idx,
                                        input logic [lm3_pkg::DIM_W-1:0] val);
    stim_row_t r;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.val = val;
    r.item = '0;
    r.check = CHK_PREDICT;
    return r;
  endfunction

  function automatic stim_row_t item_row(input logic cmd,
                                         input logic [lm3_pkg::SAMPLE_W-1:0] value,
                                         input check_t check);
    stim_row_t r;
    r.is_cfg = 1'b0;
    r.idx = '0;
    r.val = '0;
    r.item.cmd = cmd;
    r.item.sample = value;
    r.check = check;
    return r;
  endfunction

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    row_check = CHK_PREDICT;
    bad_count = 0;
    random_items = 0;
    burst_left = 0;
    tx_quiet = 1'b0;

    // 1x1 grid: every frame ends in a peak at the origin
    directed.push_back(cfg_row(lm3_pkg::CFG_GRID_ROWS, lm3_pkg::DIM_W'(1)));
    directed.push_back(cfg_row(lm3_pkg::CFG_GRID_COLS, lm3_pkg::DIM_W'(0)));
    directed.push_back(item_row(lm3_pkg::CMD_SAMPLE, 16'h8000, CHK_SILENT));
    directed.push_back(item_row(lm3_pkg::CMD_DRAIN,  16'h0000, CHK_SILENT));
    directed.push_back(item_row(lm3_pkg::CMD_DRAIN,  16'h0000, CHK_ORIGIN));
    directed.push_back(item_row(lm3_pkg::CMD_SAMPLE, 16'h7FFF, CHK_SILENT));
    directed.push_back(item_row(lm3_pkg::CMD_SAMPLE, 16'h5A5A, CHK_SILENT));
    directed.push_back(item_row(lm3_pkg::CMD_DRAIN,  16'hFFFF, CHK_ORIGIN));
    directed.push_back(cfg_row(CFG_UNUSED, lm3_pkg::DIM_W'(255)));
    directed.push_back(item_row(lm3_pkg::CMD_DRAIN,  16'hFFFF, CHK_SILENT));
    directed.push_back(item_row(lm3_pkg::CMD_DRAIN,  16'h0000, CHK_SILENT));
    directed.push_back(item_row(lm3_pkg::CMD_DRAIN,  16'h0000, CHK_ORIGIN));
    // 2x3 grid with ties, a drain tick mid-frame and the most negative sample
    directed.push_back(cfg_row(lm3_pkg::CFG_GRID_ROWS, lm3_pkg::DIM_W'(2)));
    directed.push_back(cfg_row(lm3_pkg::CFG_GRID_COLS, lm3_pkg::DIM_W'(3)));
    directed.push_back(item_row(lm3_pkg::CMD_SAMPLE, 16'h0007, CHK_PREDICT));
    directed.push_back(item_row(lm3_pkg::CMD_SAMPLE, 16'h0007, CHK_PREDICT));
    directed.push_back(item_row(lm3_pkg::CMD_SAMPLE, 16'hFFFF, CHK_PREDICT));
    directed.push_back(item_row(lm3_pkg::CMD_DRAIN,  16'h7FFF, CHK_PREDICT));
    directed.push_back(item_row(lm3_pkg::CMD_SAMPLE, 16'h0007, CHK_PREDICT));
    directed.push_back(item_row(lm3_pkg::CMD_SAMPLE, 16'h8000, CHK_PREDICT));
    for (int i = 0; i < 4; i++) begin
      directed.push_back(item_row(lm3_pkg::CMD_DRAIN, 16'h0000, CHK_PREDICT));
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        write_reg(directed[i].idx, directed[i].val);
      end else begin
        drive_item(directed[i].item, directed[i].check);
      end
    end

    while (random_items < RANDOM_ITEMS) begin
      run_phase();
    end

    in_valid = 1'b0;
    while (peaks_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (bad_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
